[rtl/core/cti_pkg.sv]
// shared types and constants for the cubic trajectory interpolator
package cti_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] REG_START_POS = 3'd0;
  localparam logic [2:0] REG_START_VEL = 3'd1;
  localparam logic [2:0] REG_END_POS   = 3'd2;
  localparam logic [2:0] REG_END_VEL   = 3'd3;
  localparam logic [2:0] REG_DURATION  = 3'd4;

  localparam logic [31:0] DURATION_RESET = 32'h0001_0000;

  // accumulator width of the horner datapath
  localparam int AccW = 54;
  // quotient bits of normalized time, one per divider stage
  localparam int DivSteps = 32;
  // horner steps and the low part of the split multiply
  localparam int HornerSteps = 3;
  localparam int SplitLo = 27;
  localparam int SplitHi = AccW - SplitLo;
  localparam int SW = DivSteps + 1;
  localparam int PlW = SplitLo + SW;
  localparam int PhW = SplitHi + SW + 1;
  localparam int SumW = AccW + SW + 1;

  typedef struct packed {
    logic clamped;
    logic err;
    logic full;
  } flags_t;

endpackage

[rtl/core/cubic_trajectory_interpolator_top.sv]
// cubic point-to-point trajectory interpolator, pipelined
//
// For each elapsed time request the block returns the position on the cubic
// that meets the configured start and end positions and velocities over the
// segment duration. All values are Q16.16; time past the duration is clamped
// and flagged, a zero duration flags an error and returns the start position,
// and the result saturates to 32 bits. One request is taken per cycle unless
// the pipeline is stalled, and each result passes one entry stage, 32 stages
// of a restoring divider that forms normalized time (one quotient bit per
// stage), three horner steps of three stages each (operand add, split
// multiply, recombine) and the output register. A stall on the result side
// freezes the whole pipeline, so the input stall follows a full and stalled
// output register. Configuration may only be written while no request is in
// flight; the velocity-times-duration coefficients settle in registers after a write.
module cubic_trajectory_interpolator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] elapsed_time_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] position_o,
  output logic        time_clamped_o,
  output logic        error_o,
  output logic        saturated_o
);

  // configuration registers
  logic signed [31:0] start_pos_q, start_vel_q, end_pos_q, end_vel_q;
  logic [31:0]        dur_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_pos_q <= '0;
      start_vel_q <= '0;
      end_pos_q   <= '0;
      end_vel_q   <= '0;
      dur_q       <= cti_pkg::DURATION_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        cti_pkg::REG_START_POS: start_pos_q <= cfg_data_i;
        cti_pkg::REG_START_VEL: start_vel_q <= cfg_data_i;
        cti_pkg::REG_END_POS:   end_pos_q   <= cfg_data_i;
        cti_pkg::REG_END_VEL:   end_vel_q   <= cfg_data_i;
        cti_pkg::REG_DURATION:  dur_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // coefficient precompute, registered behind the configuration
  logic signed [64:0] v0_prod, v1_prod;
  logic signed [47:0] v0t_q, v1t_q;
  logic signed [32:0] h_q;
  logic signed [cti_pkg::AccW-1:0] a_q, b_q, c1;

  assign v0_prod = start_vel_q * $signed({1'b0, dur_q});
  assign v1_prod = end_vel_q * $signed({1'b0, dur_q});
  assign c1      = cti_pkg::AccW'(v0t_q);

  always_ff @(posedge clk_i) begin
    // floor to q16.16
    v0t_q <= v0_prod[16 +: 48];
    v1t_q <= v1_prod[16 +: 48];
    h_q   <= 33'(end_pos_q) - 33'(start_pos_q);
    a_q   <= 3 * cti_pkg::AccW'(h_q) - 2 * cti_pkg::AccW'(v0t_q)
             - cti_pkg::AccW'(v1t_q);
    b_q   <= -2 * cti_pkg::AccW'(h_q) + cti_pkg::AccW'(v0t_q)
             + cti_pkg::AccW'(v1t_q);
  end

  // whole pipeline advances unless a held result is stalled
  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // entry stage (index 0) and divider stages 1..DivSteps
  logic                 dv_q [cti_pkg::DivSteps+1];
  logic [31:0]          dr_q [cti_pkg::DivSteps+1];
  logic [31:0]          dq_q [cti_pkg::DivSteps+1];
  cti_pkg::flags_t      df_q [cti_pkg::DivSteps+1];

  logic                 t_over;
  assign t_over = elapsed_time_i > dur_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= cti_pkg::DivSteps; k++) dv_q[k] <= 1'b0;
    end else if (en) begin
      dv_q[0] <= in_valid_i;
      for (int k = 1; k <= cti_pkg::DivSteps; k++) dv_q[k] <= dv_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // clamped time equal to the duration means s is exactly one
      df_q[0].clamped <= t_over;
      df_q[0].err     <= dur_q == '0;
      df_q[0].full    <= t_over || elapsed_time_i == dur_q;
      dr_q[0]         <= (t_over || elapsed_time_i == dur_q) ? '0 : elapsed_time_i;
      dq_q[0]         <= '0;
      for (int k = 1; k <= cti_pkg::DivSteps; k++) begin
        if ({dr_q[k-1], 1'b0} >= {1'b0, dur_q}) begin
          dr_q[k] <= 32'({dr_q[k-1], 1'b0} - {1'b0, dur_q});
          dq_q[k] <= {dq_q[k-1][30:0], 1'b1};
        end else begin
          dr_q[k] <= {dr_q[k-1][30:0], 1'b0};
          dq_q[k] <= {dq_q[k-1][30:0], 1'b0};
        end
        df_q[k] <= df_q[k-1];
      end
    end
  end

  // horner steps: b, then a, then c1
  logic                            src_v   [cti_pkg::HornerSteps];
  logic signed [cti_pkg::AccW-1:0] src_acc [cti_pkg::HornerSteps];
  logic [cti_pkg::SW-1:0]          src_s   [cti_pkg::HornerSteps];
  cti_pkg::flags_t                 src_f   [cti_pkg::HornerSteps];
  logic signed [cti_pkg::AccW-1:0] coef    [cti_pkg::HornerSteps];

  logic                            ha_v_q  [cti_pkg::HornerSteps];
  logic signed [cti_pkg::AccW-1:0] ha_op_q [cti_pkg::HornerSteps];
  logic [cti_pkg::SW-1:0]          ha_s_q  [cti_pkg::HornerSteps];
  cti_pkg::flags_t                 ha_f_q  [cti_pkg::HornerSteps];

  logic                            hb_v_q  [cti_pkg::HornerSteps];
  logic [cti_pkg::PlW-1:0]         hb_pl_q [cti_pkg::HornerSteps];
  logic signed [cti_pkg::PhW-1:0]  hb_ph_q [cti_pkg::HornerSteps];
  logic [cti_pkg::SW-1:0]          hb_s_q  [cti_pkg::HornerSteps];
  cti_pkg::flags_t                 hb_f_q  [cti_pkg::HornerSteps];

  logic                            hc_v_q   [cti_pkg::HornerSteps];
  logic signed [cti_pkg::AccW-1:0] hc_acc_q [cti_pkg::HornerSteps];
  logic [cti_pkg::SW-1:0]          hc_s_q   [cti_pkg::HornerSteps];
  cti_pkg::flags_t                 hc_f_q   [cti_pkg::HornerSteps];

  logic signed [cti_pkg::SumW-1:0] hc_sum [cti_pkg::HornerSteps];

  assign coef[0] = b_q;
  assign coef[1] = a_q;
  assign coef[2] = c1;

  always_comb begin
    src_v[0]   = dv_q[cti_pkg::DivSteps];
    src_acc[0] = '0;
    src_f[0]   = df_q[cti_pkg::DivSteps];
    src_s[0]   = df_q[cti_pkg::DivSteps].full ? {1'b1, 32'd0}
                                              : {1'b0, dq_q[cti_pkg::DivSteps]};
    for (int j = 1; j < cti_pkg::HornerSteps; j++) begin
      src_v[j]   = hc_v_q[j-1];
      src_acc[j] = hc_acc_q[j-1];
      src_s[j]   = hc_s_q[j-1];
      src_f[j]   = hc_f_q[j-1];
    end
    // floor of the product over 2^32
    for (int j = 0; j < cti_pkg::HornerSteps; j++) begin
      hc_sum[j] = $signed({hb_ph_q[j], {cti_pkg::SplitLo{1'b0}}})
                + $signed({{(cti_pkg::SumW-cti_pkg::PlW){1'b0}}, hb_pl_q[j]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < cti_pkg::HornerSteps; j++) begin
        ha_v_q[j] <= 1'b0;
        hb_v_q[j] <= 1'b0;
        hc_v_q[j] <= 1'b0;
      end
    end else if (en) begin
      for (int j = 0; j < cti_pkg::HornerSteps; j++) begin
        ha_v_q[j] <= src_v[j];
        hb_v_q[j] <= ha_v_q[j];
        hc_v_q[j] <= hb_v_q[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < cti_pkg::HornerSteps; j++) begin
        ha_op_q[j]  <= coef[j] + src_acc[j];
        ha_s_q[j]   <= src_s[j];
        ha_f_q[j]   <= src_f[j];
        hb_pl_q[j]  <= ha_op_q[j][cti_pkg::SplitLo-1:0] * ha_s_q[j];
        hb_ph_q[j]  <= $signed(ha_op_q[j][cti_pkg::AccW-1:cti_pkg::SplitLo])
                       * $signed({1'b0, ha_s_q[j]});
        hb_s_q[j]   <= ha_s_q[j];
        hb_f_q[j]   <= ha_f_q[j];
        hc_acc_q[j] <= hc_sum[j][32 +: cti_pkg::AccW];
        hc_s_q[j]   <= hb_s_q[j];
        hc_f_q[j]   <= hb_f_q[j];
      end
    end
  end

  // final add, saturation and output register
  logic signed [cti_pkg::AccW-1:0] fin_x;
  cti_pkg::flags_t                 fin_f;
  logic                            sat_hi, sat_lo;

  assign fin_x  = cti_pkg::AccW'(start_pos_q) + hc_acc_q[cti_pkg::HornerSteps-1];
  assign fin_f  = hc_f_q[cti_pkg::HornerSteps-1];
  assign sat_hi = fin_x > cti_pkg::AccW'(32'sh7FFF_FFFF);
  assign sat_lo = fin_x < -(cti_pkg::AccW'(33'sh0_8000_0000));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= hc_v_q[cti_pkg::HornerSteps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (fin_f.err) begin
        position_o     <= start_pos_q;
        time_clamped_o <= 1'b0;
        error_o        <= 1'b1;
        saturated_o    <= 1'b0;
      end else begin
        if (sat_hi)      position_o <= 32'sh7FFF_FFFF;
        else if (sat_lo) position_o <= 32'sh8000_0000;
        else             position_o <= fin_x[31:0];
        time_clamped_o <= fin_f.clamped;
        error_o        <= 1'b0;
        saturated_o    <= sat_hi || sat_lo;
      end
    end
  end

endmodule

[rtl/core/cti_checker.sv]
// port-level checks for the cubic trajectory interpolator
module cti_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] position_o,
  input logic        time_clamped_o,
  input logic        error_o,
  input logic        saturated_o
);

  // held result keeps its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(position_o))
    else $error("stalled result changed");

  // back-pressure only from a full, stalled output
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output stall");

  // zero duration result carries no other flag
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> !time_clamped_o && !saturated_o)
    else $error("error result with extra flags");

  // saturated result sits at a rail
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      position_o == 32'h7FFF_FFFF || position_o == 32'h8000_0000)
    else $error("saturated result off the rails");

endmodule

bind cubic_trajectory_interpolator_top cti_port_checker u_cti_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .position_o     (position_o),
  .time_clamped_o (time_clamped_o),
  .error_o        (error_o),
  .saturated_o    (saturated_o)
);
